/* hw/rtl/pas_pkg.sv */
`default_nettype none

package pas_pkg;

    // Event codes carried on the opcode field.
    typedef enum logic [2:0] {
        OP_START    = 3'd0,
        OP_STOP     = 3'd1,
        OP_RENDER   = 3'd2,
        OP_TAKE     = 3'd3,
        OP_COMPLETE = 3'd4
    } op_t;

    // Lifecycle mode of the sequencer.
    typedef enum logic [2:0] {
        M_OFFLINE   = 3'd0,
        M_IDLE      = 3'd1,
        M_CANCELING = 3'd2,
        M_RETRYING  = 3'd3,
        M_COMPLETE  = 3'd4,
        M_FAULTED   = 3'd5,
        M_STOPPING  = 3'd6
    } mode_t;

    // Action codes for pending, active, taken and completed actions.
    typedef enum logic [1:0] {
        A_NONE   = 2'd0,
        A_CANCEL = 2'd1,
        A_RETRY  = 2'd2
    } act_t;

    // Width of the tag and taken generation fields.
    localparam int unsigned TAG_W = 32;

endpackage

`default_nettype wire

/* hw/rtl/preemption_action_sequencer_unit.sv */
// Channel  | Handshake            | Word fields
// ---------+----------------------+-------------------------------------------------
// input    | in_valid / in_ready  | opcode, tag_generation, done_action, succeeded
// output   | out_valid / out_ready| accepted, taken_action, taken_generation,
//          |                      | mode_now, consistent
//
// An input word is captured in an input register; the event is applied to the state
// once the output register can take it, and its result is loaded into that register.
// out_valid is driven from the output register; one word per cycle is sustained while out_ready is high.
// The input register moves on whenever the output register is empty or being taken,
// so a stall on the output holds at most one word in each register.
// Reset puts the sequencer offline with all actions, flags and generations cleared.

`default_nettype none

module preemption_action_sequencer_unit
    import pas_pkg::*;
#(
    parameter int unsigned GEN_WIDTH = 32
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output      logic             in_ready,
    input  wire logic [2:0]       opcode,
    input  wire logic [TAG_W-1:0] tag_generation,
    input  wire logic [1:0]       done_action,
    input  wire logic             succeeded,
    output      logic             out_valid,
    input  wire logic             out_ready,
    output      logic             accepted,
    output      logic [1:0]       taken_action,
    output      logic [TAG_W-1:0] taken_generation,
    output      logic [2:0]       mode_now,
    output      logic             consistent
);

    // Compare width wide enough for both the tag and a generation.
    localparam int unsigned CMP_W = (GEN_WIDTH > TAG_W) ? GEN_WIDTH : TAG_W;

    // Input register.
    logic                 in_vld_reg, in_vld_next;
    logic [2:0]           op_reg;
    logic [TAG_W-1:0]     tag_reg;
    logic [1:0]           dact_reg;
    logic                 ok_reg;

    // Sequencer state.
    mode_t                mode_reg, mode_next;
    act_t                 pend_reg, pend_next;
    act_t                 actv_reg, actv_next;
    logic [GEN_WIDTH-1:0] gen_reg, gen_next;
    logic [GEN_WIDTH-1:0] agen_reg, agen_next;
    logic                 started_reg, started_next;
    logic                 stop_reg, stop_next;

    // Output register.
    logic                 out_vld_reg, out_vld_next;
    logic                 acc_reg, acc_next;
    act_t                 took_reg, took_next;
    logic [TAG_W-1:0]     tgen_reg, tgen_next;
    mode_t                mout_reg;
    logic                 cons_reg, cons_next;

    logic                 adv;
    logic [GEN_WIDTH-1:0] gen_inc;
    logic [GEN_WIDTH-1:0] gen_adv;
    logic [CMP_W-1:0]     tag_ext;
    logic [CMP_W-1:0]     agen_ext;
    logic [CMP_W-1:0]     gen_ext;
    logic                 settled;

    // The event in the input register is applied when the output register can take it.
    assign adv      = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || adv;

    assign in_vld_next  = (in_valid && in_ready) ? 1'b1 : (adv ? 1'b0 : in_vld_reg);
    assign out_vld_next = adv ? 1'b1 : (out_ready ? 1'b0 : out_vld_reg);

    // Generation counter advance skips zero on wrap.
    assign gen_inc  = gen_reg + GEN_WIDTH'(1);
    assign gen_adv  = (gen_inc == '0) ? GEN_WIDTH'(1) : gen_inc;
    assign tag_ext  = CMP_W'(tag_reg);
    assign agen_ext = CMP_W'(agen_reg);
    assign gen_ext  = CMP_W'(gen_reg);

    // Next state and event acceptance.
    always_comb
    begin
        mode_next    = mode_reg;
        pend_next    = pend_reg;
        actv_next    = actv_reg;
        gen_next     = gen_reg;
        agen_next    = agen_reg;
        started_next = started_reg;
        stop_next    = stop_reg;
        acc_next     = 1'b0;
        took_next    = A_NONE;
        tgen_next    = '0;
        case (op_reg)
            OP_START:
            begin
                if (!started_reg && !stop_reg && mode_reg == M_OFFLINE &&
                    pend_reg == A_NONE && actv_reg == A_NONE)
                begin
                    gen_next     = gen_adv;
                    mode_next    = M_IDLE;
                    started_next = 1'b1;
                    acc_next     = 1'b1;
                end
            end
            OP_STOP:
            begin
                if (started_reg && !stop_reg)
                begin
                    started_next = 1'b0;
                    pend_next    = A_NONE;
                    if (actv_reg == A_NONE)
                    begin
                        mode_next = M_OFFLINE;
                    end
                    else
                    begin
                        mode_next = M_STOPPING;
                        stop_next = 1'b1;
                    end
                    acc_next = 1'b1;
                end
            end
            OP_RENDER:
            begin
                if (started_reg && !stop_reg && pend_reg == A_NONE &&
                    actv_reg == A_NONE &&
                    (mode_reg == M_IDLE || mode_reg == M_COMPLETE ||
                     mode_reg == M_FAULTED))
                begin
                    gen_next  = gen_adv;
                    mode_next = M_CANCELING;
                    pend_next = A_CANCEL;
                    acc_next  = 1'b1;
                end
            end
            OP_TAKE:
            begin
                if (!stop_reg && actv_reg == A_NONE && pend_reg != A_NONE)
                begin
                    took_next = pend_reg;
                    tgen_next = TAG_W'(gen_ext);
                    pend_next = A_NONE;
                    actv_next = pend_reg;
                    agen_next = gen_reg;
                    acc_next  = 1'b1;
                end
            end
            OP_COMPLETE:
            begin
                if (dact_reg != A_NONE && dact_reg == actv_reg &&
                    tag_ext != '0 && tag_ext == agen_ext)
                begin
                    actv_next = A_NONE;
                    agen_next = '0;
                    acc_next  = 1'b1;
                    if (stop_reg)
                    begin
                        mode_next = M_OFFLINE;
                        pend_next = A_NONE;
                        stop_next = 1'b0;
                    end
                    else if (dact_reg == A_CANCEL)
                    begin
                        if (ok_reg)
                        begin
                            mode_next = M_RETRYING;
                            pend_next = A_RETRY;
                        end
                        else
                        begin
                            mode_next = M_FAULTED;
                        end
                    end
                    else
                    begin
                        mode_next = ok_reg ? M_COMPLETE : M_FAULTED;
                    end
                end
            end
            default:
            begin
                acc_next = 1'b0;
            end
        endcase
    end

    // Consistency check over the new state, reported with the result word.
    always_comb
    begin
        settled   = (mode_next == M_IDLE || mode_next == M_COMPLETE ||
                     mode_next == M_FAULTED);
        cons_next = 1'b1;
        if (mode_next > M_STOPPING || pend_next > A_RETRY || actv_next > A_RETRY)
            cons_next = 1'b0;
        if ((actv_next == A_NONE) != (agen_next == '0))
            cons_next = 1'b0;
        if (pend_next != A_NONE && actv_next != A_NONE)
            cons_next = 1'b0;
        if (mode_next == M_OFFLINE && (started_next || stop_next ||
            pend_next != A_NONE || actv_next != A_NONE))
            cons_next = 1'b0;
        if (mode_next == M_STOPPING && (started_next || !stop_next ||
            actv_next == A_NONE))
            cons_next = 1'b0;
        if (stop_next != (mode_next == M_STOPPING))
            cons_next = 1'b0;
        if (settled && (pend_next != A_NONE || actv_next != A_NONE))
            cons_next = 1'b0;
        if (mode_next == M_CANCELING && pend_next != A_CANCEL && actv_next != A_CANCEL)
            cons_next = 1'b0;
        if (mode_next == M_RETRYING && pend_next != A_RETRY && actv_next != A_RETRY)
            cons_next = 1'b0;
    end

    // Handshake control and sequencer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            mode_reg    <= M_OFFLINE;
            pend_reg    <= A_NONE;
            actv_reg    <= A_NONE;
            gen_reg     <= '0;
            agen_reg    <= '0;
            started_reg <= 1'b0;
            stop_reg    <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (adv)
            begin
                mode_reg    <= mode_next;
                pend_reg    <= pend_next;
                actv_reg    <= actv_next;
                gen_reg     <= gen_next;
                agen_reg    <= agen_next;
                started_reg <= started_next;
                stop_reg    <= stop_next;
            end
        end
    end

    // Input word capture.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg   <= opcode;
            tag_reg  <= tag_generation;
            dact_reg <= done_action;
            ok_reg   <= succeeded;
        end
    end

    // Result word capture.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            acc_reg  <= acc_next;
            took_reg <= took_next;
            tgen_reg <= tgen_next;
            mout_reg <= mode_next;
            cons_reg <= cons_next;
        end
    end

    assign out_valid        = out_vld_reg;
    assign accepted         = acc_reg;
    assign taken_action     = took_reg;
    assign taken_generation = tgen_reg;
    assign mode_now         = mout_reg;
    assign consistent       = cons_reg;

    // The stop flag is set exactly while the sequencer is stopping.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == M_STOPPING) == stop_reg)
        else $error("stop flag out of step with stopping mode");

    // A pending and an active action never coexist.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(pend_reg != A_NONE && actv_reg != A_NONE))
        else $error("pending and active action both present");

    // A rejected event leaves the state untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && !acc_next) |=> ($stable(mode_reg) && $stable(gen_reg) &&
        $stable(pend_reg) && $stable(actv_reg) && $stable(agen_reg)))
        else $error("rejected event changed state");

    // A handed-out action is always reported as accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && took_reg != A_NONE) |-> acc_reg)
        else $error("action taken without acceptance");

    // Once started, the generation counter is never zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |-> (gen_reg != '0))
        else $error("zero generation while started");

endmodule

`default_nettype wire
